// ===== design/ldrt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ldrt_pkg;

    // field widths
    localparam int CLASS_W  = 2;
    localparam int CODE_W   = 21;
    localparam int INDEX_W  = 12;
    localparam int BYTE_W   = 16;
    localparam int OFFSET_W = 32;

    // number of run trackers, also the most tokens one character can produce
    localparam int NUM_RUNS = 3;

    typedef enum logic [CLASS_W-1:0] {
        CLS_USELESS = 2'd0,
        CLS_ENGLISH = 2'd1,
        CLS_DIGIT   = 2'd2,
        CLS_OTHER   = 2'd3
    } class_t;

    typedef enum logic [1:0] {
        KIND_NONE    = 2'd0,
        KIND_ENGLISH = 2'd1,
        KIND_DIGIT   = 2'd2,
        KIND_MIXED   = 2'd3
    } kind_t;

    typedef enum logic [0:0] {
        CMD_CHAR  = 1'b0,
        CMD_CLEAR = 1'b1
    } cmd_t;

    // joiner characters
    localparam logic [CODE_W-1:0] CH_HASH  = 21'h23;
    localparam logic [CODE_W-1:0] CH_AMP   = 21'h26;
    localparam logic [CODE_W-1:0] CH_PLUS  = 21'h2B;
    localparam logic [CODE_W-1:0] CH_COMMA = 21'h2C;
    localparam logic [CODE_W-1:0] CH_MINUS = 21'h2D;
    localparam logic [CODE_W-1:0] CH_DOT   = 21'h2E;
    localparam logic [CODE_W-1:0] CH_AT    = 21'h40;
    localparam logic [CODE_W-1:0] CH_UNDER = 21'h5F;

    typedef struct packed {
        logic [0:0]          command;
        logic [CLASS_W-1:0]  char_class;
        logic [CODE_W-1:0]   char_code;
        logic [INDEX_W-1:0]  char_index;
        logic [BYTE_W-1:0]   byte_start_pos;
        logic [BYTE_W-1:0]   byte_next_pos;
        logic                buffer_end;
        logic [OFFSET_W-1:0] buffer_offset;
    } chr_t;

    typedef struct packed {
        logic [INDEX_W-1:0] first_index;
        logic [INDEX_W-1:0] last_index;
        logic [BYTE_W-1:0]  byte_begin;
        logic [BYTE_W-1:0]  byte_length;
    } tok_t;

    // tracker control for one step
    typedef struct packed {
        logic step;
        logic clear;
        logic member;
        logic join_hold;
        logic join_ext;
        logic buf_end;
    } run_ctl_t;

endpackage

`default_nettype wire

// ===== design/ldrt_chr_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface ldrt_chr_if;
    logic                           valid;
    logic                           ready;
    logic [0:0]                     command;
    logic [ldrt_pkg::CLASS_W-1:0]   char_class;
    logic [ldrt_pkg::CODE_W-1:0]    char_code;
    logic [ldrt_pkg::INDEX_W-1:0]   char_index;
    logic [ldrt_pkg::BYTE_W-1:0]    byte_start_pos;
    logic [ldrt_pkg::BYTE_W-1:0]    byte_next_pos;
    logic                           buffer_end;
    logic [ldrt_pkg::OFFSET_W-1:0]  buffer_offset;

    modport source (
        output valid, command, char_class, char_code, char_index,
               byte_start_pos, byte_next_pos, buffer_end, buffer_offset,
        input  ready
    );
    modport sink (
        input  valid, command, char_class, char_code, char_index,
               byte_start_pos, byte_next_pos, buffer_end, buffer_offset,
        output ready
    );
endinterface

`default_nettype wire

// ===== design/ldrt_tok_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface ldrt_tok_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     token_kind;
    logic [ldrt_pkg::OFFSET_W-1:0]  token_offset;
    logic [ldrt_pkg::BYTE_W-1:0]    token_byte_begin;
    logic [ldrt_pkg::BYTE_W-1:0]    token_byte_length;
    logic [ldrt_pkg::INDEX_W-1:0]   token_first_index;
    logic [ldrt_pkg::INDEX_W-1:0]   token_last_index;
    logic                           busy_res;
    logic                           last;

    modport source (
        output valid, token_kind, token_offset, token_byte_begin, token_byte_length,
               token_first_index, token_last_index, busy_res, last,
        input  ready
    );
    modport sink (
        input  valid, token_kind, token_offset, token_byte_begin, token_byte_length,
               token_first_index, token_last_index, busy_res, last,
        output ready
    );
endinterface

`default_nettype wire

// ===== design/ldrt_run.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ldrt_run (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire ldrt_pkg::run_ctl_t           ctl,
    input  wire logic [ldrt_pkg::INDEX_W-1:0] idx,
    input  wire logic [ldrt_pkg::BYTE_W-1:0]  byte_begin,
    input  wire logic [ldrt_pkg::BYTE_W-1:0]  byte_next,
    output      logic                         emit,
    output      ldrt_pkg::tok_t               tok,
    output      logic                         open_after
);

    logic                         open_reg;
    logic [ldrt_pkg::INDEX_W-1:0] first_reg;
    logic [ldrt_pkg::INDEX_W-1:0] last_reg;
    logic [ldrt_pkg::BYTE_W-1:0]  fb_reg;
    logic [ldrt_pkg::BYTE_W-1:0]  eb_reg;

    logic                         open_mid;
    logic                         ending;
    logic [ldrt_pkg::INDEX_W-1:0] first_next;
    logic [ldrt_pkg::INDEX_W-1:0] last_next;
    logic [ldrt_pkg::BYTE_W-1:0]  fb_next;
    logic [ldrt_pkg::BYTE_W-1:0]  eb_next;

    always_comb
    begin
        open_mid   = open_reg;
        ending     = 1'b0;
        first_next = first_reg;
        last_next  = last_reg;
        fb_next    = fb_reg;
        eb_next    = eb_reg;
        if (!open_reg)
        begin
            if (ctl.member)
            begin
                open_mid   = 1'b1;
                first_next = idx;
                last_next  = idx;
                fb_next    = byte_begin;
                eb_next    = byte_next;
            end
        end
        else if (ctl.member || ctl.join_ext)
        begin
            last_next = idx;
            eb_next   = byte_next;
        end
        else if (!ctl.join_hold)
        begin
            // run broken: token from the stored run
            ending   = 1'b1;
            open_mid = 1'b0;
        end

        emit       = ending || (ctl.buf_end && open_mid);
        open_after = !ctl.clear && open_mid && !ctl.buf_end;

        if (ending)
        begin
            tok.first_index = first_reg;
            tok.last_index  = last_reg;
            tok.byte_begin  = fb_reg;
            tok.byte_length = eb_reg - fb_reg;
        end
        else
        begin
            tok.first_index = first_next;
            tok.last_index  = last_next;
            tok.byte_begin  = fb_next;
            tok.byte_length = eb_next - fb_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= 1'b0;
        end
        else if (ctl.step)
        begin
            open_reg <= open_after;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.step && !ctl.clear)
        begin
            first_reg <= first_next;
            last_reg  <= last_next;
            fb_reg    <= fb_next;
            eb_reg    <= eb_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/letter_digit_run_tokenizer_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel  dir  kind      payload
// chr      in   request   command, char_class, char_code, char_index,
//                         byte_start_pos, byte_next_pos, buffer_end, buffer_offset
// tok      out  request   token_kind, token_offset, token_byte_begin,
//                         token_byte_length, token_first_index, token_last_index,
//                         busy_res, last
//
// each character is held in the input register, then the three run
// trackers update in one pass and load a token group into the result register
// the group drains one token per cycle while tok is not stalled, so a character
// that produces a single result sustains one character per cycle
// async active-low reset closes all runs and empties both registers
// a stall on tok holds the group; chr is still taken while the input register
// is free or moves on in the same cycle

module letter_digit_run_tokenizer_unit (
    input  wire logic   clk,
    input  wire logic   rst_n,
    ldrt_chr_if.sink    chr,
    ldrt_tok_if.source  tok
);

    localparam int N = ldrt_pkg::NUM_RUNS;

    // input register
    logic           s1_valid_reg;
    logic           s1_valid_next;
    ldrt_pkg::chr_t s1_reg;

    // result register: one slot per tracker plus a pending mask
    logic                           grp_valid_reg;
    logic                           grp_valid_next;
    logic [N-1:0]                   grp_mask_reg;
    logic [N-1:0]                   grp_mask_next;
    ldrt_pkg::tok_t                 grp_tok_reg [N];
    logic [ldrt_pkg::OFFSET_W-1:0]  grp_offset_reg;
    logic                           grp_busy_reg;

    logic   chr_take;
    logic   tok_take;
    logic   out_last;
    logic   grp_free;
    logic   s1_move;
    logic   is_clear;
    logic   is_useless;
    logic   num_join;
    logic   let_join;
    logic   busy_after;

    logic [N-1:0]   low_bit;
    logic [N-1:0]   emit;
    logic [N-1:0]   open_after;
    ldrt_pkg::tok_t run_tok [N];
    ldrt_pkg::run_ctl_t run_ctl [N];

    // --- handshake ---
    // lowest pending slot is shown first; it is the last one when no other bit
    // remains (an empty mask is the single "none" result)
    assign low_bit  = grp_mask_reg & (~grp_mask_reg + N'(1));
    assign out_last = (grp_mask_reg & ~low_bit) == '0;
    assign tok_take = tok.valid && tok.ready;
    assign grp_free = !grp_valid_reg || (tok.ready && out_last);
    assign s1_move  = s1_valid_reg && grp_free;
    assign chr.ready = !s1_valid_reg || grp_free;
    assign chr_take = chr.valid && chr.ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (chr_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (chr_take)
        begin
            s1_reg.command        <= chr.command;
            s1_reg.char_class     <= chr.char_class;
            s1_reg.char_code      <= chr.char_code;
            s1_reg.char_index     <= chr.char_index;
            s1_reg.byte_start_pos <= chr.byte_start_pos;
            s1_reg.byte_next_pos  <= chr.byte_next_pos;
            s1_reg.buffer_end     <= chr.buffer_end;
            s1_reg.buffer_offset  <= chr.buffer_offset;
        end
    end

    // --- character classification ---
    // full-width compares against ascii codes also rule out code points >= 128
    assign is_clear   = s1_reg.command == ldrt_pkg::CMD_CLEAR;
    assign is_useless = s1_reg.char_class == ldrt_pkg::CLS_USELESS;
    assign num_join   = is_useless &&
                        (s1_reg.char_code == ldrt_pkg::CH_COMMA ||
                         s1_reg.char_code == ldrt_pkg::CH_DOT);
    assign let_join   = is_useless &&
                        (s1_reg.char_code == ldrt_pkg::CH_HASH  ||
                         s1_reg.char_code == ldrt_pkg::CH_AMP   ||
                         s1_reg.char_code == ldrt_pkg::CH_PLUS  ||
                         s1_reg.char_code == ldrt_pkg::CH_MINUS ||
                         s1_reg.char_code == ldrt_pkg::CH_DOT   ||
                         s1_reg.char_code == ldrt_pkg::CH_AT    ||
                         s1_reg.char_code == ldrt_pkg::CH_UNDER);

    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            run_ctl[i].step    = s1_move;
            run_ctl[i].clear   = is_clear;
            run_ctl[i].buf_end = s1_reg.buffer_end;
        end
        // english letters: no joiners
        run_ctl[0].member    = s1_reg.char_class == ldrt_pkg::CLS_ENGLISH;
        run_ctl[0].join_hold = 1'b0;
        run_ctl[0].join_ext  = 1'b0;
        // digits: comma and dot keep the run but not its end
        run_ctl[1].member    = s1_reg.char_class == ldrt_pkg::CLS_DIGIT;
        run_ctl[1].join_hold = num_join;
        run_ctl[1].join_ext  = 1'b0;
        // mixed: joiners become part of the token
        run_ctl[2].member    = s1_reg.char_class == ldrt_pkg::CLS_ENGLISH ||
                               s1_reg.char_class == ldrt_pkg::CLS_DIGIT;
        run_ctl[2].join_hold = 1'b0;
        run_ctl[2].join_ext  = let_join;
    end

    // --- run trackers, in emission order ---
    for (genvar g = 0; g < N; g++)
    begin : g_run
        ldrt_run u_run (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (run_ctl[g]),
            .idx        (s1_reg.char_index),
            .byte_begin (s1_reg.byte_start_pos),
            .byte_next  (s1_reg.byte_next_pos),
            .emit       (emit[g]),
            .tok        (run_tok[g]),
            .open_after (open_after[g])
        );
    end

    assign busy_after = |open_after;

    // --- result register ---
    always_comb
    begin
        grp_valid_next = grp_valid_reg;
        grp_mask_next  = grp_mask_reg;
        if (s1_move)
        begin
            grp_valid_next = 1'b1;
            grp_mask_next  = is_clear ? '0 : emit;
        end
        else if (tok_take)
        begin
            grp_valid_next = !out_last;
            grp_mask_next  = grp_mask_reg & ~low_bit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grp_valid_reg <= 1'b0;
            grp_mask_reg  <= '0;
        end
        else
        begin
            grp_valid_reg <= grp_valid_next;
            grp_mask_reg  <= grp_mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            for (int i = 0; i < N; i++)
            begin
                grp_tok_reg[i] <= run_tok[i];
            end
            grp_offset_reg <= s1_reg.buffer_offset;
            grp_busy_reg   <= busy_after;
        end
    end

    // --- output select ---
    always_comb
    begin
        tok.valid             = grp_valid_reg;
        tok.busy_res          = grp_busy_reg;
        tok.last              = out_last;
        tok.token_kind        = ldrt_pkg::KIND_NONE;
        tok.token_offset      = '0;
        tok.token_byte_begin  = '0;
        tok.token_byte_length = '0;
        tok.token_first_index = '0;
        tok.token_last_index  = '0;
        case (low_bit)
            3'b001:
            begin
                tok.token_kind        = ldrt_pkg::KIND_ENGLISH;
                tok.token_offset      = grp_offset_reg;
                tok.token_byte_begin  = grp_tok_reg[0].byte_begin;
                tok.token_byte_length = grp_tok_reg[0].byte_length;
                tok.token_first_index = grp_tok_reg[0].first_index;
                tok.token_last_index  = grp_tok_reg[0].last_index;
            end
            3'b010:
            begin
                tok.token_kind        = ldrt_pkg::KIND_DIGIT;
                tok.token_offset      = grp_offset_reg;
                tok.token_byte_begin  = grp_tok_reg[1].byte_begin;
                tok.token_byte_length = grp_tok_reg[1].byte_length;
                tok.token_first_index = grp_tok_reg[1].first_index;
                tok.token_last_index  = grp_tok_reg[1].last_index;
            end
            3'b100:
            begin
                tok.token_kind        = ldrt_pkg::KIND_MIXED;
                tok.token_offset      = grp_offset_reg;
                tok.token_byte_begin  = grp_tok_reg[2].byte_begin;
                tok.token_byte_length = grp_tok_reg[2].byte_length;
                tok.token_first_index = grp_tok_reg[2].first_index;
                tok.token_last_index  = grp_tok_reg[2].last_index;
            end
            default:
            begin
                // empty group: the single result of kind none
                tok.token_kind = ldrt_pkg::KIND_NONE;
            end
        endcase
    end

endmodule

`default_nettype wire
